### hw/rtl/moesi_snooping_cache_controller_macros.svh
// Assertion macros used by the checker file of the cache controller.
`ifndef MOESI_SNOOPING_CACHE_CONTROLLER_MACROS_SVH
`define MOESI_SNOOPING_CACHE_CONTROLLER_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MSCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mscc: assertion failed");

// Concurrent assertion that is checked in every cycle, reset included.
`define MSCC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mscc: assertion failed");

`endif

### hw/rtl/mscc_pkg.sv
package mscc_pkg;

   localparam int NUM_SETS   = 128;
   localparam int NUM_WAYS   = 8;
   localparam int LINE_BYTES = 32;

   localparam int OFFSET_W = $clog2(LINE_BYTES);
   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int WAY_W    = $clog2(NUM_WAYS);
   localparam int TAG_W    = 20;
   localparam int TAG_LSB  = OFFSET_W + SET_W;
   localparam int ADDR_W   = 32;
   localparam int REQ_W    = 3;
   localparam int ID_W     = 3;
   localparam int HIT_W    = 2;
   localparam int BUS_W    = 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_RD       = 3'd0;
   localparam logic [REQ_W-1:0] REQ_WR       = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SNP_RD   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SNP_RDX  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SNP_UPGR = 3'd4;

   // Hit kind codes.
   localparam logic [HIT_W-1:0] HIT_RD_MISS = 2'd0;
   localparam logic [HIT_W-1:0] HIT_RD_HIT  = 2'd1;
   localparam logic [HIT_W-1:0] HIT_WR_MISS = 2'd2;
   localparam logic [HIT_W-1:0] HIT_WR_HIT  = 2'd3;

   // Bus transaction codes.
   localparam logic [BUS_W-1:0] BUS_NONE = 2'd0;
   localparam logic [BUS_W-1:0] BUS_RD   = 2'd1;
   localparam logic [BUS_W-1:0] BUS_RDX  = 2'd2;
   localparam logic [BUS_W-1:0] BUS_UPGR = 2'd3;

   typedef enum logic [2:0] {
      ST_I = 3'd0,
      ST_S = 3'd1,
      ST_E = 3'd2,
      ST_O = 3'd3,
      ST_M = 3'd4
   } line_state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      line_state_type   st;
      logic [WAY_W-1:0] age;
   } line_type;

   typedef line_type [NUM_WAYS-1:0] row_type;

   // Contents of a set after reset: tags zero, lines Invalid, age equal to way.
   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r[w].tag = '0;
         r[w].st  = ST_I;
         r[w].age = WAY_W'(w);
      end
      return r;
   endfunction

endpackage

### hw/rtl/mscc_if.sv
interface mscc_req_if;
   logic                          valid;
   logic                          ready;
   logic [mscc_pkg::REQ_W-1:0]    req_type;
   logic [mscc_pkg::ADDR_W-1:0]   address;
   logic [mscc_pkg::ID_W-1:0]     requester;
   logic                          shared_in;

   modport source (output valid, req_type, address, requester, shared_in, input ready);
   modport sink (input valid, req_type, address, requester, shared_in, output ready);
endinterface

interface mscc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mscc_pkg::HIT_W-1:0]    hit_kind;
   logic [mscc_pkg::WAY_W-1:0]    way;
   logic [mscc_pkg::SET_W-1:0]    set_index;
   logic [mscc_pkg::TAG_W-1:0]    tag_value;
   logic [mscc_pkg::BUS_W-1:0]    bus_request;
   logic                          writeback;
   logic                          flush;
   logic                          snoop_match;

   modport source (output valid, hit_kind, way, set_index, tag_value, bus_request, writeback,
                   flush, snoop_match, input ready);
   modport sink (input valid, hit_kind, way, set_index, tag_value, bus_request, writeback,
                 flush, snoop_match, output ready);
endinterface

interface mscc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mscc_pkg::ID_W-1:0]     own_id;

   modport source (output valid, own_id, input ready);
   modport sink (input valid, own_id, output ready);
endinterface

### hw/rtl/moesi_snooping_cache_controller.sv
// Tag, state and true-LRU controller of an 8-way, 128-set MOESI snooping cache with
// 32-byte lines. Each request is a processor read or write (hit or miss, victim
// choice, writeback flag and bus transaction) or a snooped bus request from another
// cache (state change and flush flag); every request gives exactly one response.
// The set's row is read from the set memory in the cycle the request is accepted, one
// shared tag and age comparator then walks the ways one per cycle, and the UPDATE state
// writes the updated row back and loads the response register once that register is
// free. The next request is taken in the cycle after that write, while the response may
// still wait for its transfer. Each set has a valid bit that reset clears, so the set
// memory needs no clearing pass and the block is ready from the first cycle after reset.
// The user must write the own_id register through the csr channel only while no request
// is in progress; the block itself does not enforce it. Snoops from that id and unused
// request codes leave the cache unchanged.
module moesi_snooping_cache_controller (
   input logic         clock,
   input logic         reset,
   mscc_req_if.sink    req_ch,
   mscc_rsp_if.source  rsp_ch,
   mscc_csr_if.sink    csr_ch
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      UPDATE
   } fsm_type;

   fsm_type                         state_ff;
   logic [mscc_pkg::ID_W-1:0]       own_id_ff;

   logic [mscc_pkg::REQ_W-1:0]      req_type_ff;
   logic [mscc_pkg::SET_W-1:0]      set_ff;
   logic [mscc_pkg::TAG_W-1:0]      tag_ff;
   logic [mscc_pkg::ID_W-1:0]       requester_ff;
   logic                            shared_ff;

   mscc_pkg::row_type               mem [mscc_pkg::NUM_SETS];
   logic [mscc_pkg::NUM_SETS-1:0]   set_vld_ff;
   mscc_pkg::row_type               row_ff;
   logic                            row_vld_ff;
   mscc_pkg::row_type               row_cur;
   mscc_pkg::row_type               row_in;

   logic [mscc_pkg::WAY_W-1:0]      idx_ff;
   logic                            found_ff;
   logic [mscc_pkg::WAY_W-1:0]      match_way_ff;
   logic [mscc_pkg::WAY_W-1:0]      max_age_ff;
   logic [mscc_pkg::WAY_W-1:0]      vic_way_ff;

   logic                            rsp_valid_ff;
   logic [mscc_pkg::HIT_W-1:0]      hit_kind_ff;
   logic [mscc_pkg::WAY_W-1:0]      way_ff;
   logic [mscc_pkg::SET_W-1:0]      set_index_ff;
   logic [mscc_pkg::TAG_W-1:0]      tag_value_ff;
   logic [mscc_pkg::BUS_W-1:0]      bus_ff;
   logic                            wb_ff;
   logic                            flush_ff;
   logic                            match_ff;

   logic [mscc_pkg::HIT_W-1:0]      hit_kind_in;
   logic [mscc_pkg::WAY_W-1:0]      way_in;
   logic [mscc_pkg::BUS_W-1:0]      bus_in;
   logic                            wb_in;
   logic                            flush_in;
   logic                            match_in;

   logic                            accept;
   logic                            wr_en;
   logic [mscc_pkg::SET_W-1:0]      req_set;
   mscc_pkg::line_type              cur_line;
   logic                            tag_eq;
   logic                            age_gt;
   logic                            is_cpu;
   logic                            is_wr;
   logic                            snoop_ok;
   logic [mscc_pkg::WAY_W-1:0]      sel_way;
   mscc_pkg::line_type              sel_line;
   mscc_pkg::line_state_type        cur_st;

   assign req_ch.ready = (state_ff == IDLE) && !reset;
   assign csr_ch.ready = !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_set      = req_ch.address[mscc_pkg::OFFSET_W +: mscc_pkg::SET_W];
   assign wr_en        = (state_ff == UPDATE) && (!rsp_valid_ff || rsp_ch.ready);

   // A set that was never written reads as its reset contents.
   assign row_cur = row_vld_ff ? row_ff : mscc_pkg::reset_row();

   // Shared comparator: one way per cycle against the request tag and the running age maximum.
   assign cur_line = row_cur[idx_ff];
   assign tag_eq   = (cur_line.tag == tag_ff);
   assign age_gt   = (cur_line.age > max_age_ff);

   assign is_cpu   = (req_type_ff == mscc_pkg::REQ_RD) || (req_type_ff == mscc_pkg::REQ_WR);
   assign is_wr    = (req_type_ff == mscc_pkg::REQ_WR);
   assign snoop_ok = ((req_type_ff == mscc_pkg::REQ_SNP_RD) ||
                      (req_type_ff == mscc_pkg::REQ_SNP_RDX) ||
                      (req_type_ff == mscc_pkg::REQ_SNP_UPGR)) && (requester_ff != own_id_ff);
   assign sel_way  = found_ff ? match_way_ff : vic_way_ff;
   assign sel_line = row_cur[sel_way];
   assign cur_st   = found_ff ? sel_line.st : mscc_pkg::ST_I;

   always_comb begin
      row_in      = row_cur;
      hit_kind_in = mscc_pkg::HIT_RD_MISS;
      way_in      = '0;
      bus_in      = mscc_pkg::BUS_NONE;
      wb_in       = 1'b0;
      flush_in    = 1'b0;
      match_in    = 1'b0;
      if (is_cpu) begin
         way_in      = sel_way;
         hit_kind_in = {is_wr, cur_st != mscc_pkg::ST_I};
         wb_in       = !found_ff && (sel_line.st == mscc_pkg::ST_M ||
                                     sel_line.st == mscc_pkg::ST_O);
         row_in[sel_way].tag = tag_ff;
         if (!is_wr) begin
            if (cur_st == mscc_pkg::ST_I) begin
               bus_in = mscc_pkg::BUS_RD;
               row_in[sel_way].st = shared_ff ? mscc_pkg::ST_S : mscc_pkg::ST_E;
            end
         end else begin
            case (cur_st) inside
               mscc_pkg::ST_I:                 bus_in = mscc_pkg::BUS_RDX;
               mscc_pkg::ST_O, mscc_pkg::ST_S: bus_in = mscc_pkg::BUS_UPGR;
               default:                        bus_in = mscc_pkg::BUS_NONE;
            endcase
            row_in[sel_way].st = mscc_pkg::ST_M;
         end
         // True LRU: every way younger than the accessed one ages by one.
         for (int i = 0; i < mscc_pkg::NUM_WAYS; i++) begin
            if (row_cur[i].age < sel_line.age) begin
               row_in[i].age = mscc_pkg::WAY_W'(row_cur[i].age + 1'b1);
            end
         end
         row_in[sel_way].age = '0;
      end else if (snoop_ok && found_ff) begin
         way_in   = sel_way;
         match_in = 1'b1;
         case (req_type_ff)
            mscc_pkg::REQ_SNP_RD: begin
               if (cur_st == mscc_pkg::ST_M || cur_st == mscc_pkg::ST_E) begin
                  flush_in = 1'b1;
                  row_in[sel_way].st = mscc_pkg::ST_O;
               end else if (cur_st == mscc_pkg::ST_O) begin
                  flush_in = 1'b1;
               end
            end
            mscc_pkg::REQ_SNP_RDX: begin
               flush_in = (cur_st == mscc_pkg::ST_M || cur_st == mscc_pkg::ST_O ||
                           cur_st == mscc_pkg::ST_E);
               row_in[sel_way].st = mscc_pkg::ST_I;
            end
            default: begin
               if (cur_st == mscc_pkg::ST_O || cur_st == mscc_pkg::ST_S) begin
                  row_in[sel_way].st = mscc_pkg::ST_I;
               end
            end
         endcase
      end
   end

   // Set memory: one row per set, written on update, read when a request is accepted.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[set_ff] <= row_in;
      end
      if (accept) begin
         row_ff <= mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_vld_ff <= '0;
         row_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            set_vld_ff[set_ff] <= 1'b1;
         end
         if (accept) begin
            row_vld_ff <= set_vld_ff[req_set];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         own_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            own_id_ff <= csr_ch.own_id;
         end
         // A new response loaded in the same cycle keeps the valid flag set.
         if (rsp_valid_ff && rsp_ch.ready && !wr_en) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  req_type_ff  <= req_ch.req_type;
                  set_ff       <= req_set;
                  tag_ff       <= req_ch.address[mscc_pkg::TAG_LSB +: mscc_pkg::TAG_W];
                  requester_ff <= req_ch.requester;
                  shared_ff    <= req_ch.shared_in;
                  idx_ff       <= '0;
                  found_ff     <= 1'b0;
                  match_way_ff <= '0;
                  max_age_ff   <= '0;
                  vic_way_ff   <= '0;
                  state_ff     <= SCAN;
               end
            end
            SCAN: begin
               // The lowest matching way wins; the victim is the lowest way of greatest age.
               if (!found_ff && tag_eq) begin
                  found_ff     <= 1'b1;
                  match_way_ff <= idx_ff;
               end
               if (age_gt) begin
                  max_age_ff <= cur_line.age;
                  vic_way_ff <= idx_ff;
               end
               if (idx_ff == mscc_pkg::WAY_W'(mscc_pkg::NUM_WAYS - 1)) begin
                  state_ff <= UPDATE;
               end else begin
                  idx_ff <= mscc_pkg::WAY_W'(idx_ff + 1'b1);
               end
            end
            UPDATE: begin
               if (wr_en) begin
                  rsp_valid_ff <= 1'b1;
                  hit_kind_ff  <= hit_kind_in;
                  way_ff       <= way_in;
                  set_index_ff <= set_ff;
                  tag_value_ff <= tag_ff;
                  bus_ff       <= bus_in;
                  wb_ff        <= wb_in;
                  flush_ff     <= flush_in;
                  match_ff     <= match_in;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit_kind    = hit_kind_ff;
   assign rsp_ch.way         = way_ff;
   assign rsp_ch.set_index   = set_index_ff;
   assign rsp_ch.tag_value   = tag_value_ff;
   assign rsp_ch.bus_request = bus_ff;
   assign rsp_ch.writeback   = wb_ff;
   assign rsp_ch.flush       = flush_ff;
   assign rsp_ch.snoop_match = match_ff;

endmodule

### hw/rtl/mscc_checker.sv
`include "moesi_snooping_cache_controller_macros.svh"

module mscc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        csr_ready,
   input logic                        rsp_valid,
   input logic [mscc_pkg::HIT_W-1:0]  rsp_hit_kind,
   input logic [mscc_pkg::BUS_W-1:0]  rsp_bus_request,
   input logic                        rsp_writeback,
   input logic                        rsp_flush,
   input logic                        rsp_snoop_match
);

   logic req_xfer;
   logic snoop_shape;
   logic fetch_miss;

   assign req_xfer    = req_valid && req_ready;
   assign snoop_shape = rsp_snoop_match && (rsp_hit_kind == mscc_pkg::HIT_RD_MISS) &&
                        (rsp_bus_request == mscc_pkg::BUS_NONE);
   assign fetch_miss  = !rsp_hit_kind[0] && (rsp_bus_request == mscc_pkg::BUS_RD ||
                                             rsp_bus_request == mscc_pkg::BUS_RDX);

   // One request at a time: the block is busy in the cycle after a transfer.
   `MSCC_ASSERT(a_busy_after_accept, clock, reset, req_xfer |=> !req_ready)

   // A lookup scans the ways before it responds, so no response appears right after a transfer.
   `MSCC_ASSERT(a_no_instant_rsp, clock, reset, $rose(rsp_valid) |-> !$past(req_xfer))

   // Only a matching snoop supplies a line, and a snoop reports no hit and no bus request.
   `MSCC_ASSERT(a_flush_is_snoop, clock, reset, rsp_valid && rsp_flush |-> snoop_shape)

   // A writeback comes only from a miss that fetches the line.
   `MSCC_ASSERT(a_wb_on_miss, clock, reset, rsp_valid && rsp_writeback |-> fetch_miss)

   `MSCC_ASSERT_ALWAYS(a_quiet_in_reset, clock, reset |-> !req_ready && !csr_ready)

endmodule

bind moesi_snooping_cache_controller mscc_checker u_mscc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .csr_ready       (csr_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_hit_kind    (rsp_ch.hit_kind),
   .rsp_bus_request (rsp_ch.bus_request),
   .rsp_writeback   (rsp_ch.writeback),
   .rsp_flush       (rsp_ch.flush),
   .rsp_snoop_match (rsp_ch.snoop_match)
);
